### hdl/i2cms_pkg.sv
// Shared types, phase codes and constants for the I2C master byte sequencer.
`default_nettype none
package i2cms_pkg;

    localparam int SETTLE_W = 16;
    localparam int PH_W     = 5;
    localparam int OP_W     = 2;
    localparam int BYTE_W   = 8;
    localparam int BC_W     = 4;

    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd1;
    localparam logic [BC_W-1:0]     BITS_PER_BYTE = 4'd8;

    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd2;
    localparam logic [OP_W-1:0] OP_READ  = 2'd3;

    localparam logic [PH_W-1:0] PH_IDLE          = 5'd0;
    localparam logic [PH_W-1:0] PH_ST_SDA_HI     = 5'd1;
    localparam logic [PH_W-1:0] PH_ST_SCL_HI     = 5'd2;
    localparam logic [PH_W-1:0] PH_ST_SDA_LO     = 5'd3;
    localparam logic [PH_W-1:0] PH_ST_SCL_LO     = 5'd4;
    localparam logic [PH_W-1:0] PH_SP_SDA_LO     = 5'd5;
    localparam logic [PH_W-1:0] PH_SP_SCL_HI     = 5'd6;
    localparam logic [PH_W-1:0] PH_SP_SDA_HI     = 5'd7;
    localparam logic [PH_W-1:0] PH_WR_BIT        = 5'd8;
    localparam logic [PH_W-1:0] PH_WR_SCL_HI     = 5'd9;
    localparam logic [PH_W-1:0] PH_WR_SCL_LO     = 5'd10;
    localparam logic [PH_W-1:0] PH_WR_SDA_HI     = 5'd11;
    localparam logic [PH_W-1:0] PH_WR_ACK_SCL_HI = 5'd12;
    localparam logic [PH_W-1:0] PH_WR_RELEASE    = 5'd13;
    localparam logic [PH_W-1:0] PH_WR_ACK_SAMPLE = 5'd14;
    localparam logic [PH_W-1:0] PH_RD_SDA_HI     = 5'd15;
    localparam logic [PH_W-1:0] PH_RD_RELEASE    = 5'd16;
    localparam logic [PH_W-1:0] PH_RD_SCL_HI     = 5'd17;
    localparam logic [PH_W-1:0] PH_RD_SAMPLE     = 5'd18;
    localparam logic [PH_W-1:0] PH_RD_ACK        = 5'd19;
    localparam logic [PH_W-1:0] PH_RD_ACK_SCL_HI = 5'd20;
    localparam logic [PH_W-1:0] PH_RD_ACK_SCL_LO = 5'd21;

    localparam int            APB_ADDR_W   = 3;
    localparam logic [0:0]    REG_SETTLE   = 1'b0;

    typedef struct packed {
        logic              sda_in;
        logic              send_ack;
        logic [BYTE_W-1:0] tx_byte;
        logic [OP_W-1:0]   opcode;
    } cmd_t;

    typedef struct packed {
        logic              ack_bit;
        logic [BYTE_W-1:0] rx_byte;
        logic              done_res;
        logic              busy_res;
        logic              sda_drive;
        logic              sda_level;
        logic              scl_level;
    } res_t;

endpackage
`default_nettype wire

### hdl/i2c_master_byte_sequencer_top.sv
// Top level of the I2C master byte sequencer: stream ports, result register, APB.
//
// Each input transaction is one clock tick of the I2C sequencer and yields exactly
// one result transaction showing the pin levels and status after that tick. A tick
// is processed combinationally by the phase logic and lands in a one-deep result
// register; a new tick is taken every cycle while that register is empty or being
// drained, so throughput is one transaction per cycle; each result shows the next cycle.
// The settle delay (register 0, byte address 0) sets how many ticks each pin phase
// lasts and should only be written while the sequencer is idle.
`default_nettype none
module i2c_master_byte_sequencer_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [15:0]                      s_tdata,  // opcode, tx_byte, send_ack, sda_in
    input  wire logic                             s_tuser,  // cmd_valid
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [15:0]                      m_tdata,  // scl_level, sda_level, sda_drive,
                                                            // busy_res, done_res, rx_byte, ack_bit
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [i2cms_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                      pwdata,
    output logic      [31:0]                      prdata,
    output logic                                  pready
);

    logic [i2cms_pkg::SETTLE_W-1:0] settle_ticks;
    i2cms_pkg::cmd_t                cmd;
    i2cms_pkg::res_t                res;
    i2cms_pkg::res_t                res_reg;
    logic                           valid_reg;
    logic                           valid_next;
    logic                           accept;

    assign cmd      = s_tdata[$bits(i2cms_pkg::cmd_t)-1:0];
    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    i2cms_apb u_apb (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .settle_ticks (settle_ticks)
    );

    i2cms_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (accept),
        .cmd_valid    (s_tuser),
        .cmd          (cmd),
        .settle_ticks (settle_ticks),
        .res          (res)
    );

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(16-$bits(i2cms_pkg::res_t)){1'b0}}, res_reg};

endmodule
`default_nettype wire

### hdl/i2cms_apb.sv
// APB register slave holding the settle delay.
`default_nettype none
module i2cms_apb (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [i2cms_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [31:0]                          pwdata,
    output logic      [31:0]                          prdata,
    output logic                                      pready,
    output logic      [i2cms_pkg::SETTLE_W-1:0]       settle_ticks
);

    logic [i2cms_pkg::SETTLE_W-1:0] settle_reg;
    logic [i2cms_pkg::SETTLE_W-1:0] settle_next;
    logic                           hit;

    assign hit    = (paddr[i2cms_pkg::APB_ADDR_W-1] == i2cms_pkg::REG_SETTLE);
    assign pready = 1'b1;

    always_comb begin
        settle_next = settle_reg;
        if (psel && penable && pwrite && hit) begin
            settle_next = pwdata[i2cms_pkg::SETTLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= i2cms_pkg::SETTLE_RESET;
        end else begin
            settle_reg <= settle_next;
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (hit) begin
            prdata = {{(32-i2cms_pkg::SETTLE_W){1'b0}}, settle_reg};
        end
    end

    assign settle_ticks = settle_reg;

endmodule
`default_nettype wire

### hdl/i2cms_core.sv
// Phase sequencer: pin state, shift register and counters, one step per tick.
`default_nettype none
module i2cms_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           step,
    input  wire logic                           cmd_valid,
    input  wire i2cms_pkg::cmd_t                cmd,
    input  wire logic [i2cms_pkg::SETTLE_W-1:0] settle_ticks,
    output i2cms_pkg::res_t                     res
);

    logic [i2cms_pkg::PH_W-1:0]     phase_reg,  phase_next;
    logic [i2cms_pkg::BC_W-1:0]     bc_reg,     bc_next;
    logic [i2cms_pkg::BYTE_W-1:0]   shift_reg,  shift_next;
    logic [i2cms_pkg::OP_W-1:0]     op_reg,     op_next;
    logic [i2cms_pkg::SETTLE_W-1:0] wait_reg,   wait_next;
    logic                           ackw_reg,   ackw_next;
    logic                           scl_reg,    scl_next;
    logic                           sda_reg,    sda_next;
    logic                           drv_reg,    drv_next;
    logic                           lack_reg,   lack_next;
    logic [i2cms_pkg::BYTE_W-1:0]   rx_reg,     rx_next;
    logic                           done;
    logic                           enter;
    logic [i2cms_pkg::PH_W-1:0]     target;
    logic [i2cms_pkg::PH_W-1:0]     follow;

    always_comb begin
        case (phase_reg)
            i2cms_pkg::PH_ST_SDA_HI, i2cms_pkg::PH_ST_SCL_HI, i2cms_pkg::PH_ST_SDA_LO,
            i2cms_pkg::PH_SP_SDA_LO, i2cms_pkg::PH_SP_SCL_HI,
            i2cms_pkg::PH_WR_BIT, i2cms_pkg::PH_WR_SCL_HI, i2cms_pkg::PH_WR_SDA_HI,
            i2cms_pkg::PH_WR_ACK_SCL_HI, i2cms_pkg::PH_WR_RELEASE,
            i2cms_pkg::PH_RD_SDA_HI, i2cms_pkg::PH_RD_RELEASE, i2cms_pkg::PH_RD_SCL_HI,
            i2cms_pkg::PH_RD_ACK, i2cms_pkg::PH_RD_ACK_SCL_HI: begin
                follow = phase_reg + 5'd1;
            end
            i2cms_pkg::PH_WR_SCL_LO: begin
                follow = (bc_reg < i2cms_pkg::BITS_PER_BYTE) ? i2cms_pkg::PH_WR_BIT
                                                             : i2cms_pkg::PH_WR_SDA_HI;
            end
            i2cms_pkg::PH_RD_SAMPLE: begin
                follow = (bc_reg < i2cms_pkg::BITS_PER_BYTE) ? i2cms_pkg::PH_RD_SCL_HI
                                                             : i2cms_pkg::PH_RD_ACK;
            end
            default: begin
                follow = i2cms_pkg::PH_IDLE;
            end
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        bc_next    = bc_reg;
        shift_next = shift_reg;
        op_next    = op_reg;
        wait_next  = wait_reg;
        ackw_next  = ackw_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        drv_next   = drv_reg;
        lack_next  = lack_reg;
        rx_next    = rx_reg;
        done       = 1'b0;
        enter      = 1'b0;
        target     = i2cms_pkg::PH_IDLE;

        if (phase_reg == i2cms_pkg::PH_IDLE) begin
            if (cmd_valid) begin
                op_next    = cmd.opcode;
                bc_next    = '0;
                ackw_next  = cmd.send_ack;
                shift_next = (cmd.opcode == i2cms_pkg::OP_WRITE) ? cmd.tx_byte : '0;
                enter      = 1'b1;
                case (cmd.opcode)
                    i2cms_pkg::OP_START: target = i2cms_pkg::PH_ST_SDA_HI;
                    i2cms_pkg::OP_STOP:  target = i2cms_pkg::PH_SP_SDA_LO;
                    i2cms_pkg::OP_WRITE: target = i2cms_pkg::PH_WR_BIT;
                    default:             target = i2cms_pkg::PH_RD_SDA_HI;
                endcase
            end
        end else if (wait_reg != '0) begin
            wait_next = wait_reg - 16'd1;
        end else if (follow != i2cms_pkg::PH_IDLE) begin
            enter  = 1'b1;
            target = follow;
        end else begin
            if (op_reg == i2cms_pkg::OP_READ) begin
                rx_next  = shift_reg;
                sda_next = 1'b1;
                drv_next = 1'b1;
            end
            phase_next = i2cms_pkg::PH_IDLE;
            wait_next  = '0;
            done       = 1'b1;
        end

        if (enter) begin
            case (target)
                i2cms_pkg::PH_ST_SDA_HI, i2cms_pkg::PH_SP_SDA_HI, i2cms_pkg::PH_WR_SDA_HI,
                i2cms_pkg::PH_RD_SDA_HI: begin
                    sda_next = 1'b1;
                    drv_next = 1'b1;
                end
                i2cms_pkg::PH_ST_SDA_LO, i2cms_pkg::PH_SP_SDA_LO: begin
                    sda_next = 1'b0;
                    drv_next = 1'b1;
                end
                i2cms_pkg::PH_ST_SCL_HI, i2cms_pkg::PH_SP_SCL_HI, i2cms_pkg::PH_WR_SCL_HI,
                i2cms_pkg::PH_WR_ACK_SCL_HI, i2cms_pkg::PH_RD_SCL_HI,
                i2cms_pkg::PH_RD_ACK_SCL_HI: begin
                    scl_next = 1'b1;
                end
                i2cms_pkg::PH_ST_SCL_LO, i2cms_pkg::PH_RD_ACK_SCL_LO: begin
                    scl_next = 1'b0;
                end
                i2cms_pkg::PH_WR_BIT: begin
                    sda_next = shift_next[i2cms_pkg::BYTE_W-1];
                    drv_next = 1'b1;
                end
                i2cms_pkg::PH_WR_SCL_LO: begin
                    scl_next   = 1'b0;
                    shift_next = {shift_reg[i2cms_pkg::BYTE_W-2:0], 1'b0};
                    bc_next    = bc_reg + 4'd1;
                end
                i2cms_pkg::PH_WR_RELEASE, i2cms_pkg::PH_RD_RELEASE: begin
                    drv_next = 1'b0;
                end
                i2cms_pkg::PH_WR_ACK_SAMPLE: begin
                    lack_next = cmd.sda_in;
                    scl_next  = 1'b0;
                end
                i2cms_pkg::PH_RD_SAMPLE: begin
                    shift_next = {shift_reg[i2cms_pkg::BYTE_W-2:0], cmd.sda_in};
                    bc_next    = bc_reg + 4'd1;
                    scl_next   = 1'b0;
                end
                i2cms_pkg::PH_RD_ACK: begin
                    sda_next = ~ackw_reg;
                    drv_next = 1'b1;
                end
                default: begin
                end
            endcase
            phase_next = target;
            wait_next  = (settle_ticks == '0) ? '0 : settle_ticks - 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= i2cms_pkg::PH_IDLE;
            bc_reg    <= '0;
            shift_reg <= '0;
            op_reg    <= i2cms_pkg::OP_START;
            wait_reg  <= '0;
            ackw_reg  <= 1'b0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            drv_reg   <= 1'b1;
            lack_reg  <= 1'b0;
            rx_reg    <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            bc_reg    <= bc_next;
            shift_reg <= shift_next;
            op_reg    <= op_next;
            wait_reg  <= wait_next;
            ackw_reg  <= ackw_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            drv_reg   <= drv_next;
            lack_reg  <= lack_next;
            rx_reg    <= rx_next;
        end
    end

    always_comb begin
        res.scl_level = scl_next;
        res.sda_level = sda_next;
        res.sda_drive = drv_next;
        res.busy_res  = (phase_next != i2cms_pkg::PH_IDLE);
        res.done_res  = done;
        res.rx_byte   = rx_next;
        res.ack_bit   = lack_next;
    end

endmodule
`default_nettype wire

### dv/tb.sv
// Testbench for the I2C master byte sequencer: tick stream, pin predictor, APB settle register.
`timescale 1ns / 100ps
module tb;

    typedef enum {BUS_LOW, BUS_HIGH, BUS_NOISY} slave_sda_t;
    typedef logic [i2cms_pkg::OP_W-1:0]     op_code_t;
    typedef logic [i2cms_pkg::BYTE_W-1:0]   byte_val_t;
    typedef logic [i2cms_pkg::SETTLE_W-1:0] settle_t;

    localparam logic [i2cms_pkg::APB_ADDR_W-1:0] SETTLE_ADDR = {i2cms_pkg::REG_SETTLE, 2'b00};
    localparam logic [i2cms_pkg::APB_ADDR_W-1:0] SPARE_ADDR  = 3'd4;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_OFF     = 300;
    localparam int PRINT_CAP    = 100;
    localparam int RANDOM_TICKS = 1100;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [15:0] s_tdata = '0;  // opcode, tx_byte, send_ack, sda_in
    logic s_tuser = 1'b0;       // cmd_valid
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [15:0] m_tdata;       // scl_level, sda_level, sda_drive, busy_res, done_res,
                                // rx_byte, ack_bit
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [i2cms_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    i2c_master_byte_sequencer_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // sequencer state as predicted
    logic [i2cms_pkg::PH_W-1:0]     ph = i2cms_pkg::PH_IDLE;
    logic [i2cms_pkg::BC_W-1:0]     nbits = '0;
    logic [i2cms_pkg::BYTE_W-1:0]   shreg = '0;
    logic [i2cms_pkg::BYTE_W-1:0]   rx_hold = '0;
    logic [i2cms_pkg::OP_W-1:0]     cur_op = i2cms_pkg::OP_START;
    logic [i2cms_pkg::SETTLE_W-1:0] settle = i2cms_pkg::SETTLE_RESET;
    logic [i2cms_pkg::SETTLE_W-1:0] hold_left = '0;
    logic want_ack = 1'b0;
    logic scl_q = 1'b1;
    logic sda_q = 1'b1;
    logic drv_q = 1'b1;
    logic ack_q = 1'b0;

    i2cms_pkg::res_t pin_snapshots_q[$];
    int mismatch_count = 0;
    int results_seen = 0;
    int ticks_sent = 0;
    int idle_cycles = 0;
    int sink_hold_cycles = 0;
    bit sender_gaps_on = 1'b1;
    bit sink_stalls_on = 1'b1;

    task automatic flag_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        if (mismatch_count < PRINT_CAP)
            $display("tb: result %0d %s: expected 0x%0h, got 0x%0h",
                     results_seen, what, want, got);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
            flag_mismatch(name, want, got);
    endtask

    task automatic enter_phase(input logic [i2cms_pkg::PH_W-1:0] p, input logic sda);
        case (p)
            i2cms_pkg::PH_ST_SDA_HI, i2cms_pkg::PH_SP_SDA_HI, i2cms_pkg::PH_WR_SDA_HI,
            i2cms_pkg::PH_RD_SDA_HI: begin
                sda_q = 1'b1;
                drv_q = 1'b1;
            end
            i2cms_pkg::PH_ST_SDA_LO, i2cms_pkg::PH_SP_SDA_LO: begin
                sda_q = 1'b0;
                drv_q = 1'b1;
            end
            i2cms_pkg::PH_ST_SCL_HI, i2cms_pkg::PH_SP_SCL_HI, i2cms_pkg::PH_WR_SCL_HI,
            i2cms_pkg::PH_WR_ACK_SCL_HI, i2cms_pkg::PH_RD_SCL_HI,
            i2cms_pkg::PH_RD_ACK_SCL_HI:
                scl_q = 1'b1;
            i2cms_pkg::PH_ST_SCL_LO, i2cms_pkg::PH_RD_ACK_SCL_LO:
                scl_q = 1'b0;
            i2cms_pkg::PH_WR_BIT: begin
                sda_q = shreg[i2cms_pkg::BYTE_W-1];
                drv_q = 1'b1;
            end
            i2cms_pkg::PH_WR_SCL_LO: begin
                scl_q = 1'b0;
                shreg = shreg << 1;
                nbits = nbits + 1'b1;
            end
            i2cms_pkg::PH_WR_RELEASE, i2cms_pkg::PH_RD_RELEASE:
                drv_q = 1'b0;
            i2cms_pkg::PH_WR_ACK_SAMPLE: begin
                ack_q = sda;
                scl_q = 1'b0;
            end
            i2cms_pkg::PH_RD_SAMPLE: begin
                shreg = {shreg[i2cms_pkg::BYTE_W-2:0], sda};
                nbits = nbits + 1'b1;
                scl_q = 1'b0;
            end
            i2cms_pkg::PH_RD_ACK: begin
                sda_q = !want_ack;
                drv_q = 1'b1;
            end
            default: ;
        endcase
        ph = p;
        hold_left = (settle == 0) ? '0 : settle - 1'b1;
    endtask

    function automatic logic [i2cms_pkg::PH_W-1:0] phase_after(
        input logic [i2cms_pkg::PH_W-1:0] p);
        case (p)
            i2cms_pkg::PH_ST_SCL_LO, i2cms_pkg::PH_SP_SDA_HI, i2cms_pkg::PH_WR_ACK_SAMPLE,
            i2cms_pkg::PH_RD_ACK_SCL_LO:
                return i2cms_pkg::PH_IDLE;
            i2cms_pkg::PH_WR_SCL_LO:
                return (nbits < i2cms_pkg::BITS_PER_BYTE) ? i2cms_pkg::PH_WR_BIT
                                                          : i2cms_pkg::PH_WR_SDA_HI;
            i2cms_pkg::PH_RD_SAMPLE:
                return (nbits < i2cms_pkg::BITS_PER_BYTE) ? i2cms_pkg::PH_RD_SCL_HI
                                                          : i2cms_pkg::PH_RD_ACK;
            default:
                return p + 1'b1;
        endcase
    endfunction

    function automatic logic [i2cms_pkg::PH_W-1:0] opening_phase(input op_code_t op);
        case (op)
            i2cms_pkg::OP_START: return i2cms_pkg::PH_ST_SDA_HI;
            i2cms_pkg::OP_STOP:  return i2cms_pkg::PH_SP_SDA_LO;
            i2cms_pkg::OP_WRITE: return i2cms_pkg::PH_WR_BIT;
            default:             return i2cms_pkg::PH_RD_SDA_HI;
        endcase
    endfunction

    task automatic advance_bus_model(input logic cmd_v, input i2cms_pkg::cmd_t c);
        logic done;
        logic [i2cms_pkg::PH_W-1:0] nx;
        done = 1'b0;
        if (ph == i2cms_pkg::PH_IDLE) begin
            if (cmd_v) begin
                cur_op = c.opcode;
                nbits = '0;
                want_ack = c.send_ack;
                shreg = (c.opcode == i2cms_pkg::OP_WRITE) ? c.tx_byte : '0;
                enter_phase(opening_phase(c.opcode), c.sda_in);
            end
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1'b1;
        end else begin
            nx = phase_after(ph);
            if (nx != i2cms_pkg::PH_IDLE) begin
                enter_phase(nx, c.sda_in);
            end else begin
                if (cur_op == i2cms_pkg::OP_READ) begin
                    rx_hold = shreg;
                    sda_q = 1'b1;
                    drv_q = 1'b1;
                end
                ph = i2cms_pkg::PH_IDLE;
                hold_left = '0;
                done = 1'b1;
            end
        end
        pin_snapshots_q.push_back('{ack_bit: ack_q, rx_byte: rx_hold, done_res: done,
                                    busy_res: (ph != i2cms_pkg::PH_IDLE), sda_drive: drv_q,
                                    sda_level: sda_q, scl_level: scl_q});
    endtask

    // called and returns at a falling edge; tvalid is left high, and the next call drops it during any gap
    task automatic send_tick(input logic cmd_v, input i2cms_pkg::cmd_t c);
        int gap;
        gap = sender_gaps_on ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = cmd_v;
        s_tdata = {4'b0, c};
        do @(posedge aclk); while (!s_tready);
        advance_bus_model(cmd_v, c);
        ticks_sent++;
        @(negedge aclk);
    endtask

    function automatic logic slave_sda(input slave_sda_t mode);
        case (mode)
            BUS_LOW:  return 1'b0;
            BUS_HIGH: return 1'b1;
            default:  return 1'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic i2cms_pkg::cmd_t random_cmd(input slave_sda_t mode);
        i2cms_pkg::cmd_t c;
        c = i2cms_pkg::cmd_t'($urandom);
        c.sda_in = slave_sda(mode);
        return c;
    endfunction

    task automatic idle_ticks(input int n);
        repeat (n) send_tick(1'b0, random_cmd(BUS_NOISY));
    endtask

    // issue one command, then tick until it completes; busy ticks may carry commands
    task automatic run_command(input op_code_t op, input byte_val_t tx,
                               input logic ack, input slave_sda_t mode, input bit noise);
        i2cms_pkg::cmd_t c;
        c.opcode = op;
        c.tx_byte = tx;
        c.send_ack = ack;
        c.sda_in = slave_sda(mode);
        send_tick(1'b1, c);
        while (ph != i2cms_pkg::PH_IDLE)
            send_tick(noise ? 1'b1 : 1'($urandom_range(0, 1)), random_cmd(mode));
    endtask

    task automatic quiesce();
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        while (pin_snapshots_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic apb_write(input logic [i2cms_pkg::APB_ADDR_W-1:0] addr,
                             input logic [31:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if ((addr >> 2) == i2cms_pkg::REG_SETTLE)
            settle = data[i2cms_pkg::SETTLE_W-1:0];
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic apb_check_settle();
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = SETTLE_ADDR;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata != {16'b0, settle})
            flag_mismatch("settle register read", settle, prdata);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_settle(input settle_t ticks);
        quiesce();
        apb_write(SETTLE_ADDR, {16'b0, ticks});
        apb_check_settle();
    endtask

    task automatic test_idle_pins();
        idle_ticks(4);
    endtask

    task automatic test_start_stop();
        run_command(i2cms_pkg::OP_START, 8'h00, 1'b0, BUS_HIGH, 1'b0);
        run_command(i2cms_pkg::OP_STOP, 8'hFF, 1'b1, BUS_LOW, 1'b0);
    endtask

    task automatic test_write_bytes();
        run_command(i2cms_pkg::OP_WRITE, 8'h00, 1'b0, BUS_LOW, 1'b0);
        run_command(i2cms_pkg::OP_WRITE, 8'hFF, 1'b1, BUS_HIGH, 1'b0);
        run_command(i2cms_pkg::OP_WRITE, 8'hA5, 1'b0, BUS_NOISY, 1'b0);
    endtask

    task automatic test_read_bytes();
        run_command(i2cms_pkg::OP_READ, 8'h00, 1'b1, BUS_HIGH, 1'b0);
        run_command(i2cms_pkg::OP_READ, 8'hFF, 1'b0, BUS_LOW, 1'b0);
        run_command(i2cms_pkg::OP_READ, 8'h5A, 1'b1, BUS_NOISY, 1'b0);
    endtask

    // commands on every busy tick, the completing tick included, must be dropped
    task automatic test_busy_commands();
        run_command(i2cms_pkg::OP_WRITE, 8'h3C, 1'b1, BUS_NOISY, 1'b1);
        run_command(i2cms_pkg::OP_READ, 8'hC3, 1'b0, BUS_NOISY, 1'b1);
    endtask

    task automatic test_settle_register();
        set_settle(16'd0);
        run_command(i2cms_pkg::OP_START, 8'h12, 1'b0, BUS_NOISY, 1'b0);
        run_command(i2cms_pkg::OP_READ, 8'h34, 1'b1, BUS_NOISY, 1'b0);
        set_settle(16'd2);
        run_command(i2cms_pkg::OP_WRITE, 8'h96, 1'b0, BUS_NOISY, 1'b0);
        quiesce();
        apb_write(SPARE_ADDR, $urandom);
        apb_check_settle();
        run_command(i2cms_pkg::OP_STOP, 8'h00, 1'b0, BUS_NOISY, 1'b0);
        set_settle(16'hFFFF);
        set_settle(16'd20);
        run_command(i2cms_pkg::OP_START, 8'h00, 1'b1, BUS_NOISY, 1'b0);
        set_settle(i2cms_pkg::SETTLE_RESET);
    endtask

    task automatic test_backpressure();
        sender_gaps_on = 1'b0;
        sink_hold_cycles = HOLD_OFF;
        run_command(i2cms_pkg::OP_WRITE, 8'h69, 1'b0, BUS_NOISY, 1'b0);
        quiesce();
        sender_gaps_on = 1'b1;
    endtask

    task automatic random_i2c_transfer();
        byte_val_t addr_byte;
        int n;
        bit noise;
        sender_gaps_on = ($urandom_range(0, 3) != 0);
        sink_stalls_on = ($urandom_range(0, 3) != 0);
        noise = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                run_command(op_code_t'($urandom_range(0, 3)), byte_val_t'($urandom),
                            1'($urandom_range(0, 1)), BUS_NOISY, noise);
                idle_ticks($urandom_range(0, 3));
            end
        end else begin
            addr_byte = byte_val_t'($urandom);
            n = $urandom_range(1, 4);
            run_command(i2cms_pkg::OP_START, byte_val_t'($urandom), 1'($urandom),
                        BUS_NOISY, noise);
            run_command(i2cms_pkg::OP_WRITE, addr_byte, 1'($urandom), BUS_NOISY, noise);
            for (int i = 0; i < n; i++) begin
                idle_ticks($urandom_range(0, 2));
                if (addr_byte[0])
                    run_command(i2cms_pkg::OP_READ, byte_val_t'($urandom), (i != n - 1),
                                BUS_NOISY, noise);
                else
                    run_command(i2cms_pkg::OP_WRITE, byte_val_t'($urandom), 1'($urandom),
                                BUS_NOISY, noise);
            end
            run_command(i2cms_pkg::OP_STOP, byte_val_t'($urandom), 1'($urandom),
                        BUS_NOISY, noise);
            idle_ticks($urandom_range(0, 3));
        end
    endtask

    task automatic test_random_traffic();
        int first_tick;
        int transfers;
        first_tick = ticks_sent;
        transfers = 0;
        while (ticks_sent - first_tick < RANDOM_TICKS) begin
            if (transfers % 8 == 7)
                set_settle(settle_t'($urandom_range(0, 3)));
            random_i2c_transfer();
            transfers++;
        end
    endtask

    initial begin : sink
        int stall;
        @(posedge aresetn);
        forever begin
            if (sink_hold_cycles > 0) begin
                stall = sink_hold_cycles;
                sink_hold_cycles = 0;
            end else begin
                stall = sink_stalls_on ? $urandom_range(0, 17) : 0;
            end
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin : result_check
        i2cms_pkg::res_t want;
        i2cms_pkg::res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(i2cms_pkg::res_t)-1:0];
            if (pin_snapshots_q.size() == 0) begin
                flag_mismatch("arrived with nothing outstanding", 0, got);
            end else begin
                want = pin_snapshots_q.pop_front();
                check_field("scl_level", want.scl_level, got.scl_level);
                check_field("sda_level", want.sda_level, got.sda_level);
                check_field("sda_drive", want.sda_drive, got.sda_drive);
                check_field("busy_res", want.busy_res, got.busy_res);
                check_field("done_res", want.done_res, got.done_res);
                check_field("rx_byte", want.rx_byte, got.rx_byte);
                check_field("ack_bit", want.ack_bit, got.ack_bit);
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_idle_pins();
        test_start_stop();
        test_write_bytes();
        test_read_bytes();
        test_busy_commands();
        test_settle_register();
        test_backpressure();
        test_random_traffic();
        quiesce();
        if (mismatch_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
